// ===== hdl/packbits_rle_transpose_decoder_defines.svh =====
// ---------------------------------------------------------------------------
// packbits_rle_transpose_decoder_defines.svh
// Assertion macros for the checker of the PackBits decoder.
// ---------------------------------------------------------------------------
`ifndef PACKBITS_RLE_TRANSPOSE_DECODER_DEFINES_SVH
`define PACKBITS_RLE_TRANSPOSE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PRBT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed in %m");

// Next-cycle implication, disabled while reset is held.
`define PRBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed in %m");

`endif

// ===== hdl/prbt_pkg.sv =====
// ---------------------------------------------------------------------------
// prbt_pkg
// Types and constants shared by the PackBits transpose decoder modules.
// ---------------------------------------------------------------------------
package prbt_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_COMPRESSED   = 2'd2;

  // Input operation codes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // PackBits no-op code (-128 as a signed byte).
  localparam logic [7:0] CODE_NOP = 8'h80;

  // Run state of the decoder.
  typedef enum logic [3:0] {
    MODE_CODE    = 4'b0001,
    MODE_LITERAL = 4'b0010,
    MODE_VALUE   = 4'b0100,
    MODE_REPEAT  = 4'b1000
  } mode_t;

  // One result item.
  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_value;
    logic [31:0] pixel_address;
    logic        last_pixel;
    logic [6:0]  repeats_left;
    logic        dropped;
  } res_t;

endpackage

// ===== hdl/prbt_in_if.sv =====
// ---------------------------------------------------------------------------
// prbt_in_if
// Input stream channel: one opcode and one stream byte per transfer.
// ---------------------------------------------------------------------------
interface prbt_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] in_byte;

  modport source (output valid, output opcode, output in_byte, input ready);
  modport sink (input valid, input opcode, input in_byte, output ready);
  modport monitor (input valid, input opcode, input in_byte, input ready);
endinterface

// ===== hdl/prbt_out_if.sv =====
// ---------------------------------------------------------------------------
// prbt_out_if
// Result channel: one decoded pixel report per transfer.
// ---------------------------------------------------------------------------
interface prbt_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [7:0]  pixel_value;
  logic [31:0] pixel_address;
  logic        last_pixel;
  logic [6:0]  repeats_left;
  logic        dropped;

  modport source (output valid, output pixel_valid, output pixel_value,
                  output pixel_address, output last_pixel, output repeats_left,
                  output dropped, input ready);
  modport sink (input valid, input pixel_valid, input pixel_value,
                input pixel_address, input last_pixel, input repeats_left,
                input dropped, output ready);
  modport monitor (input valid, input pixel_valid, input pixel_value,
                   input pixel_address, input last_pixel, input repeats_left,
                   input dropped, input ready);
endinterface

// ===== hdl/prbt_decode.sv =====
// ---------------------------------------------------------------------------
// prbt_decode
// Configuration registers, run state and image position, plus the
// single-pass decode of one stream item into one result.
// ---------------------------------------------------------------------------
module prbt_decode import prbt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                item_acc,
  input  logic                opcode,
  input  logic [7:0]          in_byte,
  output res_t                res
);

  logic [15:0] width_r;
  logic [15:0] height_r;
  logic        compressed_r;

  mode_t       mode_r, mode_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  rep_r, rep_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;

  logic        emit;
  logic [7:0]  emit_value;
  logic [7:0]  cnt_dec;
  logic        col_end;
  logic        row_end;
  logic [31:0] addr;

  // Configuration writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= 16'd1;
      height_r     <= 16'd1;
      compressed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r      <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r     <= cfg_data;
        CFG_COMPRESSED:   compressed_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Column-major address of the current position.
  assign addr    = ({16'd0, col_r} * {16'd0, height_r}) + {16'd0, row_r};
  assign col_end = ({1'b0, col_r} + 17'd1) >= {1'b0, width_r};
  assign row_end = ({1'b0, row_r} + 17'd1) >= {1'b0, height_r};
  assign cnt_dec = cnt_r - 8'd1;

  // Run decode, then position advance for an emitted pixel.
  always_comb begin
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    rep_nxt    = rep_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    emit       = 1'b0;
    emit_value = in_byte;
    res        = '0;

    if (opcode == OP_TICK) begin
      if (mode_r == MODE_REPEAT) begin
        cnt_nxt    = cnt_dec;
        mode_nxt   = (cnt_dec == 8'd0) ? MODE_CODE : MODE_REPEAT;
        emit       = 1'b1;
        emit_value = rep_r;
      end
    end else if (!compressed_r) begin
      emit = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_CODE: begin
          if (!in_byte[7]) begin
            mode_nxt = MODE_LITERAL;
            cnt_nxt  = in_byte + 8'd1;
          end else if (in_byte != CODE_NOP) begin
            mode_nxt = MODE_VALUE;
            cnt_nxt  = 8'(9'd257 - {1'b0, in_byte});
          end
        end
        MODE_LITERAL: begin
          cnt_nxt  = cnt_dec;
          mode_nxt = (cnt_dec == 8'd0) ? MODE_CODE : MODE_LITERAL;
          emit     = 1'b1;
        end
        MODE_VALUE: begin
          rep_nxt  = in_byte;
          cnt_nxt  = cnt_dec;
          mode_nxt = (cnt_dec == 8'd0) ? MODE_CODE : MODE_REPEAT;
          emit     = 1'b1;
        end
        MODE_REPEAT: begin
          res.dropped = 1'b1;
        end
        default: ;
      endcase
    end

    if (emit) begin
      res.pixel_valid   = 1'b1;
      res.pixel_value   = emit_value;
      res.pixel_address = addr;
      if (col_end && row_end) begin
        // Final pixel: the whole run and position state clears.
        res.last_pixel = 1'b1;
        mode_nxt       = MODE_CODE;
        cnt_nxt        = 8'd0;
        rep_nxt        = 8'd0;
        col_nxt        = 16'd0;
        row_nxt        = 16'd0;
      end else if (col_end) begin
        col_nxt = 16'd0;
        row_nxt = row_r + 16'd1;
      end else begin
        col_nxt = col_r + 16'd1;
      end
    end

    res.repeats_left = (mode_nxt == MODE_REPEAT) ? cnt_nxt[6:0] : 7'd0;
  end

  // State advances on every accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CODE;
      cnt_r  <= 8'd0;
      rep_r  <= 8'd0;
      col_r  <= 16'd0;
      row_r  <= 16'd0;
    end else if (item_acc) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      rep_r  <= rep_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

// ===== hdl/prbt_skid.sv =====
// ---------------------------------------------------------------------------
// prbt_skid
// Result register with a skid stage, so a stalled receiver costs no
// input cycle until both entries are full.
// ---------------------------------------------------------------------------
module prbt_skid import prbt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  res_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data
);

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;
  logic push;
  logic pop;

  assign push_ready = !skid_v_r;
  assign push       = push_valid && push_ready;
  assign pop        = main_v_r && pop_ready;
  assign pop_valid  = main_v_r;
  assign pop_data   = main_r;

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      main_v_r <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload; the skid entry drains into the main entry first.
  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      main_r <= skid_v_r ? skid_r : push_data;
    end else if (push) begin
      skid_r <= push_data;
    end
  end

endmodule

// ===== hdl/packbits_rle_transpose_decoder.sv =====
// ---------------------------------------------------------------------------
// packbits_rle_transpose_decoder
// PackBits run-length decoder with row-major to column-major addressing.
// ---------------------------------------------------------------------------
// Usage:
//   in_stream carries one item per transfer: opcode 0 is a stream byte, opcode
//   1 is a drain tick that releases one pending repeat pixel. out_stream
//   returns exactly one result per input item, in order, with the pixel value,
//   its address column * image_height + row, the last-pixel flag, the count of
//   repeats still pending and the dropped flag.
//   The cfg_ port writes image_width (index 0), image_height (index 1) and
//   compressed (index 2); write only while the block is idle.
//   Throughput is one item per cycle while the skid entry is empty: decode,
//   one 16 x 16 address multiply and the position advance sit between the
//   state registers and the result register, or the skid entry on a stall.
//   Reset (rst_n low, synchronous) restores width 1, height 1, raw mode and
//   clears the run state and position; the result buffer comes up empty.
//   When the receiver stalls, one more item is taken into the skid entry; then
//   in_stream.ready drops until the result register drains.
// ---------------------------------------------------------------------------
module packbits_rle_transpose_decoder import prbt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  prbt_in_if.sink             in_stream,
  prbt_out_if.source          out_stream,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  res_t dec_res;
  res_t out_res;
  logic item_acc;

  assign item_acc = in_stream.valid && in_stream.ready;

  // Decode and state.
  prbt_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item_acc  (item_acc),
    .opcode    (in_stream.opcode),
    .in_byte   (in_stream.in_byte),
    .res       (dec_res)
  );

  // Result register and skid stage.
  prbt_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_stream.valid),
    .push_ready (in_stream.ready),
    .push_data  (dec_res),
    .pop_valid  (out_stream.valid),
    .pop_ready  (out_stream.ready),
    .pop_data   (out_res)
  );

  // Result fields onto the output channel.
  assign out_stream.pixel_valid   = out_res.pixel_valid;
  assign out_stream.pixel_value   = out_res.pixel_value;
  assign out_stream.pixel_address = out_res.pixel_address;
  assign out_stream.last_pixel    = out_res.last_pixel;
  assign out_stream.repeats_left  = out_res.repeats_left;
  assign out_stream.dropped       = out_res.dropped;

endmodule

// ===== hdl/prbt_checker.sv =====
// ---------------------------------------------------------------------------
// prbt_checker
// Port-level checks of the result stream of the PackBits decoder.
// ---------------------------------------------------------------------------
`include "packbits_rle_transpose_decoder_defines.svh"

module prbt_checker (
  input logic         clk,
  input logic         rst_n,
  // Same view as the top level's result port; the checker only reads it.
  prbt_out_if.source  out_stream
);

  // A dropped byte only happens while repeats are pending, and makes no pixel.
  `PRBT_ASSERT_IMPL(a_drop_pending, out_stream.valid && out_stream.dropped, !out_stream.pixel_valid && (out_stream.repeats_left != 7'd0))

  // A result with neither pixel nor drop never leaves repeats pending.
  `PRBT_ASSERT_IMPL(a_idle_no_pending, out_stream.valid && !out_stream.pixel_valid && !out_stream.dropped, out_stream.repeats_left == 7'd0)

  // The last pixel is a real pixel and discards any pending repeats.
  `PRBT_ASSERT_IMPL(a_last_clears, out_stream.valid && out_stream.last_pixel, out_stream.pixel_valid && (out_stream.repeats_left == 7'd0))

  // A stalled result holds its pixel.
  `PRBT_ASSERT_NEXT(a_stall_hold, out_stream.valid && !out_stream.ready, out_stream.valid && $stable(out_stream.pixel_value) && $stable(out_stream.pixel_address))

endmodule

bind packbits_rle_transpose_decoder prbt_checker u_prbt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_stream (out_stream)
);

// ===== bench/packbits_rle_transpose_decoder_checker.sv =====
// ---------------------------------------------------------------------------
// packbits_rle_transpose_decoder_checker
// Watches the stream, result and register ports of the PackBits decoder.
// Every input transfer is decoded by a local copy of the decoder. The
// decoded result is queued and compared field by field with the next
// result transfer.
// ---------------------------------------------------------------------------
module packbits_rle_transpose_decoder_checker
  import prbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  prbt_in_if.monitor          in_mon,
  prbt_out_if.monitor         out_mon,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int unsigned         fail_count,
  output int unsigned         results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Image registers, as the decoder holds them.
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic        packbits_on;

  // Run state and source position of the next pixel.
  mode_t       run_mode;
  logic [7:0]  run_count;
  logic [7:0]  repeat_byte;
  logic [15:0] col_pos;
  logic [15:0] row_pos;

  res_t        expected_pixels[$];
  int unsigned fail_total;

  initial begin
    fail_total = 0;
    fail_count = 0;
    results_owed = 0;
  end

  function automatic void clear_run();
    run_mode    = MODE_CODE;
    run_count   = '0;
    repeat_byte = '0;
    col_pos     = '0;
    row_pos     = '0;
  endfunction

  // Place one pixel at the current position, then step to the next one.
  // The last pixel of the image also ends any run in progress.
  function automatic void place_pixel(input logic [7:0] value, inout res_t r);
    logic col_end;
    logic row_end;
    col_end = ({1'b0, col_pos} + 17'd1) >= {1'b0, img_w};
    row_end = ({1'b0, row_pos} + 17'd1) >= {1'b0, img_h};
    r.pixel_valid   = 1'b1;
    r.pixel_value   = value;
    r.pixel_address = 32'(col_pos) * 32'(img_h) + 32'(row_pos);
    if (col_end && row_end) begin
      r.last_pixel = 1'b1;
      clear_run();
    end else if (col_end) begin
      col_pos = '0;
      row_pos = row_pos + 16'd1;
    end else begin
      col_pos = col_pos + 16'd1;
    end
  endfunction

  // Decode one stream item into the result it must produce.
  function automatic res_t decode_item(input logic op, input logic [7:0] b);
    res_t r;
    r = '0;
    if (op == OP_TICK) begin
      // A tick drains one pending repeat. Otherwise it yields no pixel.
      if (run_mode == MODE_REPEAT) begin
        run_count = run_count - 8'd1;
        if (run_count == 8'd0) begin
          run_mode = MODE_CODE;
        end
        place_pixel(repeat_byte, r);
      end
    end else if (!packbits_on) begin
      // In raw mode every byte is a pixel, and any run state is kept unless the byte is the last pixel.
      place_pixel(b, r);
    end else begin
      case (run_mode)
        MODE_CODE: begin
          if (!b[7]) begin
            run_mode  = MODE_LITERAL;
            run_count = b + 8'd1;
          end else if (b != CODE_NOP) begin
            run_mode  = MODE_VALUE;
            run_count = 8'd1 - b;
          end
        end
        MODE_LITERAL: begin
          run_count = run_count - 8'd1;
          if (run_count == 8'd0) begin
            run_mode = MODE_CODE;
          end
          place_pixel(b, r);
        end
        MODE_VALUE: begin
          repeat_byte = b;
          run_count   = run_count - 8'd1;
          if (run_count == 8'd0) begin
            run_mode = MODE_CODE;
          end else begin
            run_mode = MODE_REPEAT;
          end
          place_pixel(b, r);
        end
        MODE_REPEAT: begin
          // Data that arrives while repeats are still pending is thrown away.
          r.dropped = 1'b1;
        end
        default: begin
        end
      endcase
    end
    r.repeats_left = (run_mode == MODE_REPEAT) ? run_count[6:0] : 7'd0;
    return r;
  endfunction

  function automatic int unsigned check_field(input string field,
                                              input logic [31:0] want_v,
                                              input logic [31:0] got_v);
    if (got_v === want_v) begin
      return 0;
    end
    $display("%0t: %s expected %0h, actual %0h", $time, field, want_v, got_v);
    return 1;
  endfunction

  // Follow register writes, compare each result transfer and queue the
  // result of each input transfer. A result never leaves in the cycle in
  // which its input arrives, so the comparison comes first.
  always @(posedge clk) begin
    res_t        want;
    res_t        got;
    int unsigned wrong;
    wrong = 0;
    if (!rst_n) begin
      img_w       = 16'd1;
      img_h       = 16'd1;
      packbits_on = 1'b0;
      clear_run();
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  img_w = cfg_data;
          CFG_IMAGE_HEIGHT: img_h = cfg_data;
          CFG_COMPRESSED:   packbits_on = cfg_data[0];
          default: begin
          end
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        got.pixel_valid   = out_mon.pixel_valid;
        got.pixel_value   = out_mon.pixel_value;
        got.pixel_address = out_mon.pixel_address;
        got.last_pixel    = out_mon.last_pixel;
        got.repeats_left  = out_mon.repeats_left;
        got.dropped       = out_mon.dropped;
        if (expected_pixels.size() == 0) begin
          wrong = 1;
          $display("%0t: result expected none, actual %h", $time, got);
        end else begin
          want = expected_pixels.pop_front();
          wrong += check_field("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
          wrong += check_field("pixel_value", 32'(want.pixel_value), 32'(got.pixel_value));
          wrong += check_field("pixel_address", want.pixel_address, got.pixel_address);
          wrong += check_field("last_pixel", 32'(want.last_pixel), 32'(got.last_pixel));
          wrong += check_field("repeats_left", 32'(want.repeats_left),
                               32'(got.repeats_left));
          wrong += check_field("dropped", 32'(want.dropped), 32'(got.dropped));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_pixels.push_back(decode_item(in_mon.opcode, in_mon.in_byte));
      end
    end
    fail_total += wrong;
    fail_count   <= fail_total;
    results_owed <= expected_pixels.size();
  end

endmodule

// ===== bench/packbits_rle_transpose_decoder_test.sv =====
// ---------------------------------------------------------------------------
// packbits_rle_transpose_decoder_test
// Stimulus for the PackBits transpose decoder. A short directed pass covers
// one-pixel images, every code kind, drops, idle ticks and raw bytes inside a
// run. Then random phases each set the image size and mode and send mostly
// well-formed runs, mixed with noise and broken runs. Both channels stall
// at random. The checker beside the block decides the verdict.
// ---------------------------------------------------------------------------
module packbits_rle_transpose_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 1350;
  // Register index with no register behind it.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned items_sent;
  int unsigned cycles;
  bit          steady;

  prbt_in_if  in_ch();
  prbt_out_if out_ch();

  packbits_rle_transpose_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  packbits_rle_transpose_decoder_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The result side stalls at random, with some long stretches always ready.
  initial begin
    int unsigned roll;
    int unsigned hold;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(1, 12);
      end else if (roll < 65) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(40, 100);
      end else if (roll < 95) begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b0;
        hold = $urandom_range(10, 30);
      end
      repeat (hold) @(posedge clk);
    end
  end

  // One register write per cycle. The caller lowers the write enable.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_image(input logic [15:0] w, input logic [15:0] h, input logic rle);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_COMPRESSED, CfgDataW'(rle));
    cfg_we <= 1'b0;
  endtask

  // Hold one item until its transfer, then leave a random gap unless the
  // phase runs without gaps.
  task automatic send_item(input logic op, input logic [7:0] b);
    int unsigned roll;
    int unsigned gap;
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    roll = $urandom_range(0, 99);
    if (steady || roll < 70) begin
      gap = 0;
    end else if (roll < 95) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every result has come back, plus a short margin for latency.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  // Image sizes are mostly small, so that images end often.
  function automatic logic [15:0] pick_dim();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) begin
      return 16'($urandom_range(1, 8));
    end else if (roll == 7) begin
      return 16'd1;
    end else if (roll == 8) begin
      return 16'hFFFF;
    end
    return 16'($urandom_range(1, 65535));
  endfunction

  // One random PackBits run or no-op code, sometimes broken: a stray tick,
  // a byte that lands on pending repeats, a repeat run cut short, or noise.
  task automatic send_packet();
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
      send_item(OP_DATA, 8'(n));
      for (int unsigned k = 0; k <= n; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
        send_item(OP_DATA, 8'($urandom_range(0, 255)));
      end
    end else if (kind < 80) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 128) : $urandom_range(2, 9);
      send_item(OP_DATA, 8'(257 - n));
      send_item(OP_DATA, 8'($urandom_range(0, 255)));
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : n - 1;
      for (int unsigned k = 0; k < cut; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(OP_DATA, 8'($urandom_range(0, 255)));
        end
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
      end
    end else if (kind < 85) begin
      send_item(OP_DATA, CODE_NOP);
    end else begin
      send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned phase_end;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_IMAGE_WIDTH;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_DATA;
    in_ch.in_byte <= '0;
    steady     = 1'b0;
    items_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A write to the spare index must change nothing. Then one-pixel raw
    // images: every byte is a last pixel, and a lone tick yields nothing.
    write_reg(CFG_SPARE, '1);
    set_image(16'd1, 16'd1, 1'b0);
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_TICK, 8'h00);
    settle();

    // A 3 x 2 compressed image. The no-op code comes first. Then a full
    // 128-pixel repeat, with a byte dropped while repeats are pending. The
    // image ends before the repeat is done, so the rest of it is discarded.
    set_image(16'd3, 16'd2, 1'b1);
    send_item(OP_DATA, CODE_NOP);
    send_item(OP_DATA, 8'h81);
    send_item(OP_DATA, 8'h5A);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_DATA, 8'h33);
    repeat (5) send_item(OP_TICK, 8'h00);
    // One-byte literal, shortest repeat, two-byte literal.
    send_item(OP_DATA, 8'h00);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'hFF);
    send_item(OP_DATA, 8'h01);
    send_item(OP_TICK, 8'h00);
    send_item(OP_DATA, 8'h01);
    send_item(OP_DATA, 8'h80);
    send_item(OP_DATA, 8'h7F);
    settle();

    // Largest image. A repeat is left pending, then a raw byte passes
    // through while the run is kept, and ticks still drain it.
    set_image(16'hFFFF, 16'hFFFF, 1'b1);
    send_item(OP_DATA, 8'hFE);
    send_item(OP_DATA, 8'hC3);
    settle();
    write_reg(CFG_COMPRESSED, CfgDataW'(1'b0));
    cfg_we <= 1'b0;
    send_item(OP_DATA, 8'h11);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    settle();

    // Random phases, each with its own image size and mode.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      set_image(pick_dim(), pick_dim(), logic'($urandom_range(0, 4) != 0));
      steady    = ($urandom_range(0, 3) == 0);
      phase_end = items_sent + $urandom_range(40, 120);
      while (items_sent < phase_end) begin
        send_packet();
      end
      settle();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
